// ----- rtl/degree_histogram_hub_threshold_assert.svh -----
// ----------------------------------------------------------------------------
// Degree histogram assertion macros
// Concurrent assertion shorthands used by the degree histogram RTL.
// ----------------------------------------------------------------------------
`ifndef DEGREE_HISTOGRAM_HUB_THRESHOLD_ASSERT_SVH
`define DEGREE_HISTOGRAM_HUB_THRESHOLD_ASSERT_SVH

// Check a consequent in the same cycle as the antecedent.
`define DHH_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("degree histogram assertion failed");

// Check a consequent in the cycle after the antecedent.
`define DHH_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("degree histogram assertion failed");

`endif

// ----- rtl/dhh_pkg.sv -----
// ----------------------------------------------------------------------------
// Degree histogram package
// Widths, limits, register indexes and control types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package dhh_pkg;

    localparam int NUM_BINS_DEF = 4096;

    localparam int DEGREE_W = 24;
    localparam int COUNT_W  = 25;
    localparam int EDGE_W   = 40;
    localparam int THR_W    = 12;
    localparam int SHARE_W  = 16;
    localparam int Q_W      = 17;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_SHARE   = 2'd1;

    localparam logic [COUNT_W-1:0] BUFFER_LIMIT_RESET = 25'd65536;
    localparam logic [SHARE_W-1:0] EDGE_SHARE_RESET   = 16'd32768;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [EDGE_W-1:0]  EDGE_MAX  = {EDGE_W{1'b1}};
    localparam logic [Q_W-1:0]     ONE_Q16   = 17'd65536;

    // Scan modes
    localparam logic SCAN_LIMIT = 1'b0;
    localparam logic SCAN_SHARE = 1'b1;

    typedef struct packed {
        logic clear;   // restart the accumulators
        logic mode;    // SCAN_LIMIT or SCAN_SHARE
        logic issue;   // a bin read is issued this cycle
    } dhh_scan_ctl_t;

    typedef struct packed {
        logic busy;    // bins still in flight
        logic found;   // threshold reached in this pass
    } dhh_scan_sts_t;

endpackage

`default_nettype wire

// ----- rtl/dhh_bin_mem.sv -----
// ----------------------------------------------------------------------------
// Bin count memory
// One write port and one registered read port, read-first on a collision.
// ----------------------------------------------------------------------------
`default_nettype none

module dhh_bin_mem #(
    parameter int NUM_BINS = 4096,
    parameter int BIN_W    = $clog2(NUM_BINS)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [BIN_W-1:0]            waddr,
    input  wire logic [dhh_pkg::COUNT_W-1:0] wdata,
    input  wire logic [BIN_W-1:0]            raddr,
    output logic      [dhh_pkg::COUNT_W-1:0] rdata
);
    import dhh_pkg::*;

    logic [COUNT_W-1:0] mem [NUM_BINS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/dhh_div.sv -----
// ----------------------------------------------------------------------------
// Share divider
// Restoring divider: floor(dividend * 2^16 / divisor), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dhh_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dhh_pkg::EDGE_W-1:0] dividend,
    input  wire logic [dhh_pkg::EDGE_W-1:0] divisor,
    output logic                            busy,
    output logic      [dhh_pkg::Q_W-1:0]    quotient
);
    import dhh_pkg::*;

    localparam int STEP_W = $clog2(Q_W + 1);

    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [EDGE_W:0]   rem_reg;
    logic [EDGE_W-1:0] div_reg;
    logic [Q_W-1:0]    q_reg;

    logic              ge;
    logic [EDGE_W:0]   diff;
    logic [EDGE_W:0]   rem_sel;

    // Dividend never exceeds the divisor, so the remainder stays below it
    assign ge      = rem_reg >= {1'b0, div_reg};
    assign diff    = rem_reg - {1'b0, div_reg};
    assign rem_sel = ge ? diff : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(Q_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend};
            div_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= {rem_sel[EDGE_W-1:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ----- rtl/dhh_scan.sv -----
// ----------------------------------------------------------------------------
// Bin scan accumulator
// Weight each bin by its degree, accumulate vertices and edges, catch threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module dhh_scan #(
    parameter int NUM_BINS = 4096,
    parameter int BIN_W    = $clog2(NUM_BINS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dhh_pkg::dhh_scan_ctl_t      ctl,
    input  wire logic [BIN_W-1:0]            issue_idx,
    input  wire logic [dhh_pkg::COUNT_W-1:0] rd_data,
    input  wire logic [dhh_pkg::COUNT_W-1:0] buffer_limit,
    input  wire logic [dhh_pkg::EDGE_W-1:0]  target,
    output dhh_pkg::dhh_scan_sts_t           sts,
    output logic      [dhh_pkg::EDGE_W-1:0]  sum,
    output logic      [BIN_W-1:0]            thr_idx,
    output logic      [dhh_pkg::EDGE_W-1:0]  hit_sum,
    output logic      [dhh_pkg::COUNT_W-1:0] hit_verts
);
    import dhh_pkg::*;

    localparam int PROD_W = BIN_W + COUNT_W;
    localparam int ACC_W  = ((PROD_W > EDGE_W) ? PROD_W : EDGE_W) + 1;

    logic               s1_valid_reg;
    logic [BIN_W-1:0]   s1_idx_reg;
    logic               s2_valid_reg;
    logic [BIN_W-1:0]   s2_idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [COUNT_W-1:0] cnt_reg;

    logic [EDGE_W-1:0]  sum_reg;
    logic [COUNT_W-1:0] verts_reg;
    logic               found_reg;
    logic [BIN_W-1:0]   thr_reg;
    logic [EDGE_W-1:0]  hit_sum_reg;
    logic [COUNT_W-1:0] hit_verts_reg;

    logic [ACC_W-1:0]   sum_wide;
    logic [EDGE_W-1:0]  sum_sat;
    logic [COUNT_W:0]   verts_wide;
    logic [COUNT_W-1:0] verts_sat;
    logic               hit;

    assign sum_wide   = ACC_W'(sum_reg) + ACC_W'(prod_reg);
    assign sum_sat    = (sum_wide > ACC_W'(EDGE_MAX)) ? EDGE_MAX : sum_wide[EDGE_W-1:0];
    assign verts_wide = {1'b0, verts_reg} + {1'b0, cnt_reg};
    assign verts_sat  = verts_wide[COUNT_W] ? COUNT_MAX : verts_wide[COUNT_W-1:0];
    assign hit        = (ctl.mode == SCAN_SHARE) ? (sum_sat > target)
                                                 : (verts_sat >= buffer_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.issue;
            s2_valid_reg <= s1_valid_reg;
            if (ctl.clear)
            begin
                found_reg <= 1'b0;
            end
            else if (s2_valid_reg && hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Multiply stage, then accumulate stage
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= issue_idx;
        s2_idx_reg <= s1_idx_reg;
        prod_reg   <= PROD_W'(s1_idx_reg) * PROD_W'(rd_data);
        cnt_reg    <= rd_data;
        if (ctl.clear)
        begin
            sum_reg       <= '0;
            verts_reg     <= '0;
            thr_reg       <= '0;
            hit_sum_reg   <= '0;
            hit_verts_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            sum_reg   <= sum_sat;
            verts_reg <= verts_sat;
            if (!found_reg && hit)
            begin
                thr_reg       <= s2_idx_reg;
                hit_sum_reg   <= sum_sat;
                hit_verts_reg <= verts_sat;
            end
        end
    end

    assign sts.busy  = s1_valid_reg | s2_valid_reg;
    assign sts.found = found_reg;
    assign sum       = sum_reg;
    assign thr_idx   = thr_reg;
    assign hit_sum   = hit_sum_reg;
    assign hit_verts = hit_verts_reg;

endmodule

`default_nettype wire

// ----- rtl/degree_histogram_hub_threshold.sv -----
// ----------------------------------------------------------------------------
// Degree histogram with hub thresholds
// Counts vertex degrees into bins, then scans them for hub thresholds.
// ----------------------------------------------------------------------------
// Each input item carries one vertex degree and is counted into a bin held in
// a single-port-read, single-port-write memory; while a graph loads the block
// takes one item per cycle, with a forwarding register covering back-to-back
// hits on one bin. After the item marked last, two full descending sweeps of
// the memory run: the first sums the edge total and finds the buffer-limit
// threshold, the second finds the edge-share threshold and zeroes each bin as
// it reads it. The result is posted once the second sweep has drained, the
// share division, which runs alongside the second sweep, is done and the
// output register is free. No items are taken during the sweeps, but a
// finished result waits in the output register while the next graph loads.
// After reset a clearing pass zeroes every bin of the memory before the
// first item is taken; configuration writes go through at any time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "degree_histogram_hub_threshold_assert.svh"

module degree_histogram_hub_threshold #(
    parameter int NUM_BINS = dhh_pkg::NUM_BINS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_write,
    input  wire logic [dhh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dhh_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [dhh_pkg::DEGREE_W-1:0]    degree,
    input  wire logic                            last,
    // result items
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [dhh_pkg::EDGE_W-1:0]      edge_total,
    output logic      [dhh_pkg::THR_W-1:0]       limit_threshold,
    output logic      [dhh_pkg::Q_W-1:0]         limit_share,
    output logic      [dhh_pkg::THR_W-1:0]       share_threshold,
    output logic      [dhh_pkg::COUNT_W-1:0]     share_vertices,
    output logic                                 degree_clipped
);
    import dhh_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam logic [BIN_W-1:0] TOP_IDX = BIN_W'(NUM_BINS - 1);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // zero the memory after reset
    localparam logic [2:0] ST_LOAD  = 3'd1;  // count incoming degrees
    localparam logic [2:0] ST_DRAIN = 3'd2;  // let the last increment land
    localparam logic [2:0] ST_PASSA = 3'd3;  // edge total and limit sweep
    localparam logic [2:0] ST_WAITA = 3'd4;  // drain the scan pipeline
    localparam logic [2:0] ST_MUL   = 3'd5;  // form share target, start divide
    localparam logic [2:0] ST_PASSB = 3'd6;  // share sweep, zero each bin
    localparam logic [2:0] ST_WAITB = 3'd7;  // drain, then post the result

    logic [2:0]         state_reg, state_next;
    logic [BIN_W-1:0]   scan_idx_reg, scan_idx_next;

    logic [COUNT_W-1:0] buffer_limit_reg;
    logic [SHARE_W-1:0] edge_share_reg;
    logic               clip_reg;

    // load pipeline: read at accept, increment and write in the next cycle
    logic               accept;
    logic               clip_in;
    logic [BIN_W-1:0]   bin_in;
    logic               ld_valid_reg;
    logic [BIN_W-1:0]   ld_bin_reg;
    logic               fw_valid_reg;
    logic [BIN_W-1:0]   fw_bin_reg;
    logic [COUNT_W-1:0] fw_cnt_reg;
    logic [COUNT_W-1:0] ld_base;
    logic [COUNT_W-1:0] ld_cnt;

    // memory ports
    logic               mem_we;
    logic [BIN_W-1:0]   mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic [BIN_W-1:0]   mem_raddr;
    logic [COUNT_W-1:0] mem_rdata;

    // scan and divider
    dhh_scan_ctl_t      scan_ctl;
    dhh_scan_sts_t      scan_sts;
    logic [EDGE_W-1:0]  scan_sum;
    logic [BIN_W-1:0]   scan_thr;
    logic [EDGE_W-1:0]  scan_hit_sum;
    logic [COUNT_W-1:0] scan_hit_verts;
    logic [EDGE_W-1:0]  target_reg;
    logic [EDGE_W+SHARE_W-1:0] target_prod;
    logic               div_busy;
    logic [Q_W-1:0]     div_q;

    // pass A results held through pass B
    logic [EDGE_W-1:0]  total_reg;
    logic [BIN_W-1:0]   lim_thr_reg;
    logic               lim_found_reg;

    logic [BIN_W+THR_W-1:0] lim_thr_ext;
    logic [BIN_W+THR_W-1:0] sh_thr_ext;
    logic               post;

    // output registers
    logic               out_valid_reg;
    logic [EDGE_W-1:0]  edge_total_reg;
    logic [THR_W-1:0]   limit_threshold_reg;
    logic [Q_W-1:0]     limit_share_reg;
    logic [THR_W-1:0]   share_threshold_reg;
    logic [COUNT_W-1:0] share_vertices_reg;
    logic               degree_clipped_reg;

    // ------------------------------------------------------------------------
    // Configuration: ignore writes to indexes beyond the register list
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_limit_reg <= BUFFER_LIMIT_RESET;
            edge_share_reg   <= EDGE_SHARE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BUFFER_LIMIT: buffer_limit_reg <= cfg_data[COUNT_W-1:0];
                REG_EDGE_SHARE:   edge_share_reg   <= cfg_data[SHARE_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input side: saturate the degree into the top bin
    // ------------------------------------------------------------------------
    assign in_ready = (state_reg == ST_LOAD);
    assign accept   = in_valid & in_ready;
    assign clip_in  = degree >= DEGREE_W'(NUM_BINS);
    assign bin_in   = clip_in ? TOP_IDX : degree[BIN_W-1:0];

    // The read issued with the item right behind misses the write in flight:
    // take the count from the forwarding register instead
    assign ld_base = (fw_valid_reg && (fw_bin_reg == ld_bin_reg)) ? fw_cnt_reg : mem_rdata;
    assign ld_cnt  = (ld_base == COUNT_MAX) ? COUNT_MAX : ld_base + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
            clip_reg     <= 1'b0;
        end
        else
        begin
            ld_valid_reg <= accept;
            fw_valid_reg <= ld_valid_reg;
            if (post)
            begin
                clip_reg <= 1'b0;
            end
            else if (accept && clip_in)
            begin
                clip_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ld_bin_reg <= bin_in;
        fw_bin_reg <= ld_bin_reg;
        fw_cnt_reg <= ld_cnt;
    end

    // ------------------------------------------------------------------------
    // Memory ports: clear and share sweep write zero, loading writes the increment
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_CLEAR || state_reg == ST_PASSB)
        begin
            mem_we    = 1'b1;
            mem_waddr = scan_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = ld_valid_reg;
            mem_waddr = ld_bin_reg;
            mem_wdata = ld_cnt;
        end
        mem_raddr = (state_reg == ST_LOAD) ? bin_in : scan_idx_reg;
    end

    dhh_bin_mem #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    assign post = (state_reg == ST_WAITB) && !scan_sts.busy && !div_busy
                  && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (scan_idx_reg == '0)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg - 1'b1;
                end
            end
            ST_LOAD:
            begin
                if (accept && last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                scan_idx_next = TOP_IDX;
                state_next    = ST_PASSA;
            end
            ST_PASSA:
            begin
                if (scan_idx_reg == '0)
                begin
                    state_next = ST_WAITA;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg - 1'b1;
                end
            end
            ST_WAITA:
            begin
                if (!scan_sts.busy)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                scan_idx_next = TOP_IDX;
                state_next    = ST_PASSB;
            end
            ST_PASSB:
            begin
                if (scan_idx_reg == '0)
                begin
                    state_next = ST_WAITB;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg - 1'b1;
                end
            end
            ST_WAITB:
            begin
                if (post)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            scan_idx_reg <= TOP_IDX;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    // ------------------------------------------------------------------------
    // Scans and the share divider
    // ------------------------------------------------------------------------
    assign scan_ctl.clear = (state_reg == ST_DRAIN) || (state_reg == ST_MUL);
    assign scan_ctl.mode  = (state_reg == ST_PASSB || state_reg == ST_WAITB)
                            ? SCAN_SHARE : SCAN_LIMIT;
    assign scan_ctl.issue = (state_reg == ST_PASSA) || (state_reg == ST_PASSB);

    dhh_scan #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .issue_idx    (scan_idx_reg),
        .rd_data      (mem_rdata),
        .buffer_limit (buffer_limit_reg),
        .target       (target_reg),
        .sts          (scan_sts),
        .sum          (scan_sum),
        .thr_idx      (scan_thr),
        .hit_sum      (scan_hit_sum),
        .hit_verts    (scan_hit_verts)
    );

    // Share target: edge total times the configured fraction, Q0.16
    assign target_prod = (EDGE_W+SHARE_W)'(scan_sum) * (EDGE_W+SHARE_W)'(edge_share_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            target_reg    <= target_prod[EDGE_W+SHARE_W-1:SHARE_W];
            total_reg     <= scan_sum;
            lim_thr_reg   <= scan_thr;
            lim_found_reg <= scan_sts.found;
        end
    end

    dhh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_MUL),
        .dividend (scan_hit_sum),
        .divisor  (scan_sum),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------------
    // Result register: thresholds keep their low bits only
    // ------------------------------------------------------------------------
    assign lim_thr_ext = {{THR_W{1'b0}}, lim_thr_reg};
    assign sh_thr_ext  = {{THR_W{1'b0}}, scan_thr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (post)
        begin
            edge_total_reg      <= total_reg;
            limit_threshold_reg <= lim_thr_ext[THR_W-1:0];
            limit_share_reg     <= (lim_found_reg && total_reg != '0) ? div_q : '0;
            share_threshold_reg <= sh_thr_ext[THR_W-1:0];
            share_vertices_reg  <= scan_hit_verts;
            degree_clipped_reg  <= clip_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign edge_total      = edge_total_reg;
    assign limit_threshold = limit_threshold_reg;
    assign limit_share     = limit_share_reg;
    assign share_threshold = share_threshold_reg;
    assign share_vertices  = share_vertices_reg;
    assign degree_clipped  = degree_clipped_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DHH_ASSERT_NOW(a_no_load_during_sweep, clk, rst_n,
        (state_reg == ST_PASSA || state_reg == ST_PASSB), !ld_valid_reg)
    `DHH_ASSERT_NOW(a_pass_a_drained, clk, rst_n, (state_reg == ST_MUL), !scan_sts.busy)
    `DHH_ASSERT_NOW(a_share_at_most_one, clk, rst_n, out_valid_reg,
        (limit_share_reg <= ONE_Q16))
    `DHH_ASSERT_NEXT(a_last_starts_drain, clk, rst_n, (accept && last),
        (state_reg == ST_DRAIN))

endmodule

`default_nettype wire
